FILE: hw/rtl/wha_pkg.sv
// ----------------------------------------------------------------------------
// wha_pkg
// Shared widths, codes and reset values of the weighted histogram accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package wha_pkg;

  // port field widths
  localparam int OP_W       = 3;
  localparam int X_W        = 32;
  localparam int WEIGHT_W   = 16;
  localparam int BIN_W      = 10;
  localparam int OUT_CNT_W  = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // default storage shape
  localparam int DEF_BIN_STORE_DEPTH = 1024;
  localparam int DEF_COUNT_WIDTH     = 48;

  // largest regular bin count the index field can express
  localparam int MAX_BINS = 1022;

  // configuration reset values
  localparam logic signed [X_W-1:0] X_LOWER_RST       = 32'sd0;
  localparam logic signed [X_W-1:0] X_UPPER_RST       = 32'sd65536;
  localparam logic [BIN_W-1:0]      NUM_BINS_RST      = 10'd1022;
  localparam logic [X_W-1:0]        INV_BIN_WIDTH_RST = 32'd67043328;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_FILL  = 3'd0,
    OP_READ  = 3'd1,
    OP_MAX   = 3'd2,
    OP_MIN   = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOWER       = 2'd0,
    CFG_X_UPPER       = 2'd1,
    CFG_NUM_BINS      = 2'd2,
    CFG_INV_BIN_WIDTH = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wha_ram.sv
// ----------------------------------------------------------------------------
// wha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wha_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_histogram_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator
// Weighted histogram with equal-width bins plus underflow and overflow bins.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per beat (fill, read bin, find max, find min, clear)
//   out_* : one result beat per operation: bin, its content, running total
//   cfg_* : register writes, taken at any time, meant only while idle
// The bins live in one memory with a registered read; fills are
// read-modify-writes and max, min and clear are sweeps over that single
// port pair, and the block works on one operation at a time.
//   fill      : compare, 32x32 multiply, bin select and read, add and
//               write back, output
//   max / min : one bin read per cycle over bins 1..N
//   clear     : one entry zeroed per cycle over all BIN_STORE_DEPTH entries
// A new input beat is taken the cycle after the previous result is loaded.
// After reset a clearing pass zeroes all BIN_STORE_DEPTH entries, one per
// cycle, while in_ready stays low; register writes are still taken.
// The output register holds a result until out_ready; while it is held the
// next operation finishes its work and then waits at its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_accumulator
  import wha_pkg::*;
#(
  parameter int BIN_STORE_DEPTH = DEF_BIN_STORE_DEPTH,
  parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // operation channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [OP_W-1:0]              in_operation,
  input  wire logic signed [X_W-1:0]        in_x_value,
  input  wire logic [WEIGHT_W-1:0]          in_weight,
  input  wire logic [BIN_W-1:0]             in_bin_index,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [BIN_W-1:0]                  out_result_bin,
  output logic [OUT_CNT_W-1:0]              out_bin_content,
  output logic [OUT_CNT_W-1:0]              out_total_weight,
  // configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int AW      = $clog2(BIN_STORE_DEPTH);
  localparam int CAP_INT = (MAX_BINS < BIN_STORE_DEPTH - 2) ? MAX_BINS : BIN_STORE_DEPTH - 2;
  localparam logic [BIN_W-1:0] BIN_CAP  = BIN_W'(CAP_INT);
  localparam logic [AW-1:0]    LAST_ADR = AW'(BIN_STORE_DEPTH - 1);

  typedef enum logic [9:0] {
    S_INIT = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_MUL  = 10'b00_0000_0100,
    S_BIN  = 10'b00_0000_1000,
    S_RD   = 10'b00_0001_0000,
    S_UPD  = 10'b00_0010_0000,
    S_SCAN = 10'b00_0100_0000,
    S_SEND = 10'b00_1000_0000,
    S_CLR  = 10'b01_0000_0000,
    S_PUSH = 10'b10_0000_0000
  } state_t;

  // saturating add of a weight to a count
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [WEIGHT_W-1:0]    b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [X_W-1:0] x_lower_r;
  logic signed [X_W-1:0] x_upper_r;
  logic [BIN_W-1:0]      num_bins_r;
  logic [X_W-1:0]        inv_bin_width_r;

  // per-operation working registers
  op_t                   op_r;
  logic [WEIGHT_W-1:0]   weight_r;
  logic [BIN_W-1:0]      idx_r;
  logic                  in_range_r;
  logic                  below_r;
  logic                  above_r;
  logic [X_W-1:0]        d_r;
  logic [X_W-1:0]        prod_hi_r;
  logic [BIN_W-1:0]      bin_r;
  logic [AW-1:0]         cnt_r;
  logic                  pend_vld_r;
  logic [AW-1:0]         pend_idx_r;
  logic [BIN_W-1:0]      res_bin_r;
  logic [COUNT_WIDTH-1:0] res_content_r;
  logic [COUNT_WIDTH-1:0] total_r;

  // output register
  logic                  out_valid_r;
  logic [BIN_W-1:0]      out_result_bin_r;
  logic [OUT_CNT_W-1:0]  out_bin_content_r;
  logic [OUT_CNT_W-1:0]  out_total_weight_r;

  // memory port signals
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic                   in_fire;
  logic                   out_free;
  logic [BIN_W-1:0]       n_eff;
  logic [BIN_W-1:0]       n_plus1;
  logic [X_W-1:0]         d_calc;
  logic [2*X_W-1:0]       prod_w;
  logic [BIN_W-1:0]       bin_calc;
  logic [COUNT_WIDTH-1:0] fill_sum;
  logic                   scan_take;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // effective regular bin count
  always_comb begin
    if (num_bins_r == '0) begin
      n_eff = BIN_W'(1);
    end else if (num_bins_r > BIN_CAP) begin
      n_eff = BIN_CAP;
    end else begin
      n_eff = num_bins_r;
    end
  end
  assign n_plus1 = n_eff + BIN_W'(1);

  // offset from the lower edge and scaled product
  assign d_calc = in_x_value - x_lower_r;
  assign prod_w = d_r * inv_bin_width_r;

  // bin select with clamp to the last regular bin
  always_comb begin
    if (below_r) begin
      bin_calc = '0;
    end else if (above_r) begin
      bin_calc = n_plus1;
    end else if (prod_hi_r >= X_W'(n_eff)) begin
      bin_calc = n_eff;
    end else begin
      bin_calc = prod_hi_r[BIN_W-1:0] + BIN_W'(1);
    end
  end

  assign fill_sum = sat_add(ram_rdata, weight_r);

  // first bin of a scan is always taken, later ones only on strict improvement
  always_comb begin
    if (pend_idx_r == AW'(1)) begin
      scan_take = 1'b1;
    end else if (op_r == OP_MAX) begin
      scan_take = ram_rdata > res_content_r;
    end else begin
      scan_take = ram_rdata < res_content_r;
    end
  end

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      S_INIT, S_CLR: begin
        ram_we = 1'b1;
      end
      S_BIN: begin
        ram_raddr = AW'(bin_calc);
      end
      S_RD: begin
        ram_raddr = AW'(idx_r);
      end
      S_SCAN: begin
        ram_raddr = cnt_r;
      end
      S_UPD: begin
        ram_we    = (op_r == OP_FILL);
        ram_waddr = AW'(bin_r);
        ram_wdata = fill_sum;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (cnt_r == LAST_ADR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_operation))
            OP_FILL:  state_nxt = S_MUL;
            OP_READ:  state_nxt = S_RD;
            OP_MAX:   state_nxt = S_SCAN;
            OP_MIN:   state_nxt = S_SCAN;
            OP_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_PUSH;
          endcase
        end
      end
      S_MUL:  state_nxt = S_BIN;
      S_BIN:  state_nxt = S_UPD;
      S_RD:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_PUSH;
      S_SCAN: begin
        if (cnt_r == AW'(n_eff)) state_nxt = S_SEND;
      end
      S_SEND: state_nxt = S_PUSH;
      S_CLR: begin
        if (cnt_r == LAST_ADR) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, counters and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      total_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_INIT, S_CLR: begin
          cnt_r <= cnt_r + AW'(1);
          if (state_r == S_CLR && cnt_r == LAST_ADR) total_r <= '0;
        end
        S_IDLE: begin
          pend_vld_r <= 1'b0;
          if (op_t'(in_operation) == OP_CLEAR) begin
            cnt_r <= '0;
          end else begin
            cnt_r <= AW'(1);
          end
        end
        S_SCAN: begin
          cnt_r      <= cnt_r + AW'(1);
          pend_vld_r <= 1'b1;
        end
        S_UPD: begin
          if (op_r == OP_FILL) total_r <= sat_add(total_r, weight_r);
        end
        default: begin
          pend_vld_r <= pend_vld_r;
        end
      endcase
    end
  end

  // operation payload and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r          <= op_t'(in_operation);
        weight_r      <= in_weight;
        idx_r         <= in_bin_index;
        in_range_r    <= (in_bin_index <= n_plus1);
        below_r       <= (in_x_value < x_lower_r);
        above_r       <= (in_x_value >= x_upper_r);
        d_r           <= d_calc;
        res_bin_r     <= '0;
        res_content_r <= '0;
      end
      S_MUL: begin
        prod_hi_r <= prod_w[2*X_W-1:X_W];
      end
      S_BIN: begin
        bin_r <= bin_calc;
      end
      S_UPD: begin
        if (op_r == OP_FILL) begin
          res_bin_r     <= bin_r;
          res_content_r <= fill_sum;
        end else begin
          res_bin_r     <= idx_r;
          res_content_r <= in_range_r ? ram_rdata : '0;
        end
      end
      S_SCAN, S_SEND: begin
        pend_idx_r <= cnt_r;
        if (pend_vld_r && scan_take) begin
          res_bin_r     <= BIN_W'(pend_idx_r);
          res_content_r <= ram_rdata;
        end
      end
      default: begin
        bin_r <= bin_r;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lower_r       <= X_LOWER_RST;
      x_upper_r       <= X_UPPER_RST;
      num_bins_r      <= NUM_BINS_RST;
      inv_bin_width_r <= INV_BIN_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_LOWER:       x_lower_r       <= cfg_data;
        CFG_X_UPPER:       x_upper_r       <= cfg_data;
        CFG_NUM_BINS:      num_bins_r      <= cfg_data[BIN_W-1:0];
        CFG_INV_BIN_WIDTH: inv_bin_width_r <= cfg_data;
        default:           num_bins_r      <= num_bins_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUSH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUSH && out_free) begin
      out_result_bin_r   <= res_bin_r;
      out_bin_content_r  <= OUT_CNT_W'(res_content_r);
      out_total_weight_r <= OUT_CNT_W'(total_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_bin   = out_result_bin_r;
  assign out_bin_content  = out_bin_content_r;
  assign out_total_weight = out_total_weight_r;

  // bin store
  wha_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BIN_STORE_DEPTH)
  ) u_bin_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/wha_checker.sv
// ----------------------------------------------------------------------------
// wha_checker
// Port-level checks of the weighted histogram accumulator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wha_checker
  import wha_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [BIN_W-1:0]      out_result_bin,
  input wire logic [OUT_CNT_W-1:0]  out_bin_content,
  input wire logic [OUT_CNT_W-1:0]  out_total_weight
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bin)
      && $stable(out_bin_content) && $stable(out_total_weight))
    else $error("result beat changed while stalled");

  // one operation at a time: busy right after an input beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input beat taken while previous operation in flight");

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a bin never holds more than the running total
  a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bin_content <= out_total_weight)
    else $error("bin content exceeds total weight");

endmodule

bind weighted_histogram_accumulator wha_checker u_wha_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_bin   (out_result_bin),
  .out_bin_content  (out_bin_content),
  .out_total_weight (out_total_weight)
);

`default_nettype wire

FILE: sim/weighted_histogram_accumulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator_tb
// Drives fill, read, max/min scan, clear and spare operation beats through
// the histogram engine under several bin layouts, including collapsed and
// inverted edges and out-of-range bin counts. A mirror of the bin store in
// a small scoreboard predicts every result beat, and each field is compared.
// Sender gaps and receiver stalls vary phase by phase.
// ----------------------------------------------------------------------------

module weighted_histogram_accumulator_tb;
  import wha_pkg::*;

  localparam int SPARE_OP_LO     = int'(OP_CLEAR) + 1;
  localparam int SPARE_OP_HI     = (1 << OP_W) - 1;
  localparam int SETTLE_CYCLES   = DEF_BIN_STORE_DEPTH + 8;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int NUM_PHASES      = 9;
  localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
  localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] ONE_X = 32'sd65536;

  typedef struct packed {
    logic [BIN_W-1:0]     bin;
    logic [OUT_CNT_W-1:0] content;
    logic [OUT_CNT_W-1:0] total;
  } hist_result_t;

  // mirror of the bin store and the register file, plus pending results
  class hist_scoreboard;
    logic signed [X_W-1:0] lo_edge;
    logic signed [X_W-1:0] hi_edge;
    logic [BIN_W-1:0]      bin_count;
    logic [X_W-1:0]        bins_per_unit;
    logic [OUT_CNT_W-1:0]  bin_store [DEF_BIN_STORE_DEPTH];
    logic [OUT_CNT_W-1:0]  weight_sum;
    hist_result_t          pending [$];
    int                    errors;
    int                    results_checked;
    int                    ops_seen [1 << OP_W];

    function new();
      lo_edge         = X_LOWER_RST;
      hi_edge         = X_UPPER_RST;
      bin_count       = NUM_BINS_RST;
      bins_per_unit   = INV_BIN_WIDTH_RST;
      weight_sum      = '0;
      errors          = 0;
      results_checked = 0;
      foreach (bin_store[i]) bin_store[i] = '0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_X_LOWER:       lo_edge = data;
        CFG_X_UPPER:       hi_edge = data;
        CFG_NUM_BINS:      bin_count = data[BIN_W-1:0];
        CFG_INV_BIN_WIDTH: bins_per_unit = data;
        default: ;
      endcase
    endfunction

    // zero acts as one bins, anything above the cap as the cap
    function int unsigned regular_bins();
      int unsigned n;
      n = bin_count;
      if (n < 1) n = 1;
      if (n > MAX_BINS) n = MAX_BINS;
      if (n > DEF_BIN_STORE_DEPTH - 2) n = DEF_BIN_STORE_DEPTH - 2;
      return n;
    endfunction

    function logic [OUT_CNT_W-1:0] sat_add(logic [OUT_CNT_W-1:0] a, logic [WEIGHT_W-1:0] w);
      logic [OUT_CNT_W:0] s;
      s = {1'b0, a} + w;
      return s[OUT_CNT_W] ? '1 : s[OUT_CNT_W-1:0];
    endfunction

    // underflow, overflow, else integer part of offset times bins per unit
    function int unsigned locate_bin(logic signed [X_W-1:0] x, int unsigned n);
      logic [X_W-1:0]   d;
      logic [2*X_W-1:0] prod;
      logic [X_W-1:0]   k;
      if (x < lo_edge) return 0;
      if (x >= hi_edge) return n + 1;
      d    = x - lo_edge;
      prod = {{X_W{1'b0}}, d} * {{X_W{1'b0}}, bins_per_unit};
      k    = prod[2*X_W-1:X_W];
      if (k >= n) return n;
      return k + 1;
    endfunction

    function void log_operation(logic [OP_W-1:0] op, logic signed [X_W-1:0] x,
                                logic [WEIGHT_W-1:0] w, logic [BIN_W-1:0] idx);
      int unsigned  n;
      int unsigned  b;
      int unsigned  i;
      hist_result_t r;
      n = regular_bins();
      r = '0;
      ops_seen[op]++;
      case (op)
        OP_FILL: begin
          b            = locate_bin(x, n);
          bin_store[b] = sat_add(bin_store[b], w);
          weight_sum   = sat_add(weight_sum, w);
          r.bin        = BIN_W'(b);
          r.content    = bin_store[b];
        end
        OP_READ: begin
          r.bin = idx;
          if (idx <= n + 1) r.content = bin_store[idx];
        end
        OP_MAX, OP_MIN: begin
          // ties keep the lowest bin
          r.bin     = BIN_W'(1);
          r.content = bin_store[1];
          for (i = 2; i <= n; i++) begin
            if ((op == OP_MAX) ? (bin_store[i] > r.content) : (bin_store[i] < r.content)) begin
              r.bin     = BIN_W'(i);
              r.content = bin_store[i];
            end
          end
        end
        OP_CLEAR: begin
          foreach (bin_store[j]) bin_store[j] = '0;
          weight_sum = '0;
        end
        default: ;
      endcase
      r.total = weight_sum;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [BIN_W-1:0] bin, logic [OUT_CNT_W-1:0] content,
                               logic [OUT_CNT_W-1:0] total);
      hist_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: bin %0d content %0d total %0d",
                 $time, bin, content, total);
        return;
      end
      e = pending.pop_front();
      results_checked++;
      if (bin !== e.bin) begin
        errors++;
        $display("%0t: result_bin mismatch: expected %0d, actual %0d", $time, e.bin, bin);
      end
      if (content !== e.content) begin
        errors++;
        $display("%0t: bin_content mismatch (bin %0d): expected %0d, actual %0d",
                 $time, e.bin, e.content, content);
      end
      if (total !== e.total) begin
        errors++;
        $display("%0t: total_weight mismatch: expected %0d, actual %0d",
                 $time, e.total, total);
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation = '0;
  logic signed [X_W-1:0] in_x_value   = '0;
  logic [WEIGHT_W-1:0]   in_weight    = '0;
  logic [BIN_W-1:0]      in_bin_index = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [BIN_W-1:0]      out_result_bin;
  logic [OUT_CNT_W-1:0]  out_bin_content;
  logic [OUT_CNT_W-1:0]  out_total_weight;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  hist_scoreboard hist_sb = new();

  weighted_histogram_accumulator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_x_value       (in_x_value),
    .in_weight        (in_weight),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_bin   (out_result_bin),
    .out_bin_content  (out_bin_content),
    .out_total_weight (out_total_weight),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // beat monitor: results checked, accepted operations predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        hist_sb.check_result(out_result_bin, out_bin_content, out_total_weight);
      if (in_valid && in_ready)
        hist_sb.log_operation(in_operation, in_x_value, in_weight, in_bin_index);
    end
  end

  task automatic push_op(input logic [OP_W-1:0] op, input logic signed [X_W-1:0] x,
                         input logic [WEIGHT_W-1:0] w, input logic [BIN_W-1:0] idx);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_x_value   <= x;
    in_weight    <= w;
    in_bin_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // sender gap after the beat
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hist_sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hist_sb.write_reg(idx, data);
  endtask

  task automatic load_config(input logic [X_W-1:0] lo, input logic [X_W-1:0] hi,
                             input logic [BIN_W-1:0] n, input logic [X_W-1:0] inv);
    write_reg(CFG_X_LOWER, lo);
    write_reg(CFG_X_UPPER, hi);
    write_reg(CFG_NUM_BINS, n);
    write_reg(CFG_INV_BIN_WIDTH, inv);
    cfg_valid <= 1'b0;
  endtask

  // edges of the fields and every operation under the reset layout
  task automatic run_directed();
    int c;
    push_op(OP_FILL, X_MIN, 16'hFFFF, '0);
    push_op(OP_FILL, X_MAX, 16'd1, '0);
    push_op(OP_FILL, 32'sd0, 16'd0, '0);
    push_op(OP_FILL, ONE_X - 1, 16'hFFFF, '0);
    push_op(OP_FILL, ONE_X, 16'd100, '0);
    push_op(OP_FILL, -32'sd1, 16'd7, '0);
    push_op(OP_FILL, ONE_X / 2, 16'd300, '0);
    push_op(OP_READ, '0, '0, 10'd0);
    push_op(OP_READ, '0, '0, 10'd1023);
    push_op(OP_READ, '0, '0, 10'd1022);
    push_op(OP_READ, '0, '0, 10'd1);
    push_op(OP_MAX, '0, '0, '0);
    push_op(OP_MIN, '0, '0, '0);
    for (c = SPARE_OP_LO; c <= SPARE_OP_HI; c++) push_op(OP_W'(c), X_MAX, 16'hFFFF, '1);
    push_op(OP_CLEAR, X_MIN, 16'hFFFF, '1);
    // all bins equal after clear
    push_op(OP_MAX, '0, '0, '0);
    push_op(OP_MIN, '0, '0, '0);
    push_op(OP_READ, '0, '0, 10'd1023);
    push_op(OP_FILL, 32'sd0, 16'hFFFF, '1);
    push_op(OP_READ, '0, '0, 10'd1);
  endtask

  task automatic random_op();
    int unsigned           n;
    int unsigned           pick;
    longint                span;
    logic [OP_W-1:0]       op;
    logic signed [X_W-1:0] x;
    logic [WEIGHT_W-1:0]   w;
    logic [BIN_W-1:0]      idx;
    n    = hist_sb.regular_bins();
    span = longint'(hist_sb.hi_edge) - longint'(hist_sb.lo_edge);

    pick = $urandom_range(99);
    if (pick < 62)      op = OP_FILL;
    else if (pick < 80) op = OP_READ;
    else if (pick < 87) op = OP_MAX;
    else if (pick < 94) op = OP_MIN;
    else if (pick < 96) op = OP_CLEAR;
    else                op = OP_W'($urandom_range(SPARE_OP_HI, SPARE_OP_LO));

    // x mostly inside the range, some right at the edges
    pick = $urandom_range(99);
    if (pick < 65 && span > 0)
      x = X_W'(longint'(hist_sb.lo_edge) + longint'($urandom) % span);
    else if (pick < 73) x = hist_sb.lo_edge - $urandom_range(1, 0);
    else if (pick < 81) x = hist_sb.hi_edge - $urandom_range(1, 0);
    else if (pick < 85) x = $urandom_range(1, 0) ? X_MIN : X_MAX;
    else                x = $urandom;

    pick = $urandom_range(99);
    if (pick < 10)      w = '0;
    else if (pick < 20) w = '1;
    else                w = WEIGHT_W'($urandom_range(16'hFFFF));

    // bin index anywhere in the field, around the overflow bin and just past it, or up to it
    pick = $urandom_range(99);
    if (pick < 50)      idx = BIN_W'($urandom_range(1023));
    else if (pick < 80) idx = BIN_W'(n + $urandom_range(3) - 1);
    else                idx = BIN_W'($urandom_range(n + 1));

    if ($urandom_range(99) < 2) drain();
    push_op(op, x, w, idx);
  endtask

  initial begin
    int          p;
    int          spare_ops;
    int unsigned n;
    longint      lo;
    longint      span;
    longint      inv;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;
        1: load_config(-8 * ONE_X, 8 * ONE_X, 10'd16, 32'd65536);
        2: load_config(X_MIN, X_MAX, 10'd0, 32'd0);
        3: load_config(X_MIN, X_MAX, 10'd1023, 32'hFFFF_FFFF);
        // inverted edges, mismatched scale
        4: load_config(5 * ONE_X, -3 * ONE_X, 10'd7, $urandom);
        // collapsed range
        5: load_config(ONE_X, ONE_X, 10'd1, $urandom);
        default: begin
          n    = $urandom_range(64, 1);
          span = $urandom_range(32'h4000_0000, n * 256);
          lo   = longint'($urandom_range(32'h4000_0000)) - 64'sh2000_0000;
          inv  = (longint'(n) << 32) / span;
          if (inv > 64'shFFFF_FFFF) inv = 64'shFFFF_FFFF;
          load_config(X_W'(lo), X_W'(lo + span), BIN_W'(n), X_W'(inv));
        end
      endcase

      // idle mixes: none, sender gaps, receiver stalls, both
      send_idle_pct  = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 30 : 0;
      recv_stall_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 30 : 0;
      repeat (ITEMS_PER_PHASE) random_op();
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    spare_ops = 0;
    for (p = SPARE_OP_LO; p <= SPARE_OP_HI; p++) spare_ops += hist_sb.ops_seen[p];

    $display("ran %0d fills, %0d reads, %0d max and %0d min scans, %0d clears, %0d spare ops",
             hist_sb.ops_seen[OP_FILL], hist_sb.ops_seen[OP_READ], hist_sb.ops_seen[OP_MAX],
             hist_sb.ops_seen[OP_MIN], hist_sb.ops_seen[OP_CLEAR], spare_ops);
    $display("%0d result beats checked over %0d bin layouts and four idle/stall mixes",
             hist_sb.results_checked, NUM_PHASES);
    if (hist_sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
